// ===== design/lkv_pkg.sv =====
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants for the LRU key-value cache
// Request/response payloads, the scan token passed along the cell row,
// the broadcast update command and the controller state encoding.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam int KEY_BITS     = 32;
    localparam int VALUE_BITS   = 32;
    localparam int CAP_BITS     = 5;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;
    // slot numbers and ranks in the token/command; covers up to 256 entries
    localparam int SLOT_BITS    = 8;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // register index (byte address / 4)
    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_NONE     = 1'b1
    } reg_idx_t;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } op_t;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef struct packed {
        op_t                            operation;
        logic signed [KEY_BITS-1:0]     key;
        logic signed [VALUE_BITS-1:0]   value;
    } req_t;

    typedef struct packed {
        logic                           found;
        logic signed [VALUE_BITS-1:0]   read_value;
    } rsp_t;

    // search token, accumulated cell by cell
    typedef struct packed {
        logic                           active;
        logic                           hit;
        slot_t                          hit_slot;
        slot_t                          hit_rank;
        logic signed [VALUE_BITS-1:0]   hit_data;
        logic                           old_found;
        slot_t                          old_slot;
        slot_t                          old_rank;
        logic                           free_found;
        slot_t                          free_slot;
    } scan_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic                           touch;
        logic                           write_data;
        slot_t                          hit_slot;
        slot_t                          hit_rank;
        logic                           insert;
        logic                           evict;
        slot_t                          victim_slot;
        slot_t                          new_slot;
        logic signed [KEY_BITS-1:0]     key;
        logic signed [VALUE_BITS-1:0]   data;
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_COMMIT = 2'd2
    } state_t;

endpackage

// ===== design/lkv_cell.sv =====
// ----------------------------------------------------------------------------
// lkv_cell: one entry of the LRU cache row
// Holds valid/key/data/rank, folds itself into the passing scan token and
// applies the broadcast update command.
// ----------------------------------------------------------------------------
module lkv_cell #(
    parameter int ENTRIES = 16,
    parameter int SLOT    = 0
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  lkv_pkg::scan_t                          scan_in,
    output lkv_pkg::scan_t                          scan_out,
    input  logic signed [lkv_pkg::KEY_BITS-1:0]     key,
    input  lkv_pkg::upd_t                           upd
);
    import lkv_pkg::*;

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam slot_t MY_SLOT = SLOT_BITS'(SLOT);

    logic                           valid_reg;
    logic [RANK_W-1:0]              rank_reg;
    logic signed [KEY_BITS-1:0]     key_reg;
    logic signed [VALUE_BITS-1:0]   data_reg;
    scan_t                          scan_reg;
    scan_t                          scan_next;
    slot_t                          rank_ext;
    logic                           victim_here;
    logic                           valid_next;
    logic [RANK_W-1:0]              rank_next;

    assign rank_ext    = SLOT_BITS'(rank_reg);
    assign victim_here = upd.insert && upd.evict && (upd.victim_slot == MY_SLOT);

    // fold this entry into the token
    always_comb
    begin
        scan_next = scan_in;
        if (valid_reg && (key_reg == key) && !scan_in.hit)
        begin
            scan_next.hit      = 1'b1;
            scan_next.hit_slot = MY_SLOT;
            scan_next.hit_rank = rank_ext;
            scan_next.hit_data = data_reg;
        end
        // ranks are distinct; ties go to the later slot
        if (valid_reg && (!scan_in.old_found || (rank_ext >= scan_in.old_rank)))
        begin
            scan_next.old_found = 1'b1;
            scan_next.old_slot  = MY_SLOT;
            scan_next.old_rank  = rank_ext;
        end
        if (!valid_reg && !scan_in.free_found)
        begin
            scan_next.free_found = 1'b1;
            scan_next.free_slot  = MY_SLOT;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (upd.touch)
        begin
            if (upd.hit_slot == MY_SLOT)
                rank_next = '0;
            else if (valid_reg && (rank_ext < upd.hit_rank))
                rank_next = RANK_W'(rank_reg + 1'b1);
        end
        else if (upd.insert)
        begin
            if (upd.new_slot == MY_SLOT)
            begin
                valid_next = 1'b1;
                rank_next  = '0;
            end
            else if (victim_here)
                valid_next = 1'b0;
            else if (valid_reg)
                rank_next = RANK_W'(rank_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            scan_reg  <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.insert && (upd.new_slot == MY_SLOT))
        begin
            key_reg  <= upd.key;
            data_reg <= upd.data;
        end
        else if (upd.touch && upd.write_data && (upd.hit_slot == MY_SLOT))
            data_reg <= upd.data;
    end

    assign scan_out = scan_reg;

endmodule

// ===== design/lru_key_value_cache.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store, LRU replacement
// Row of ENTRIES cells searched by a token, then updated by a broadcast.
// ----------------------------------------------------------------------------
// Usage
//   request channel (request/request_valid/request_stall): one get or set.
//   response channel (response/response_valid/response_stall): one response
//   per get (found, read_value; read_value is all ones on a miss). A set
//   gives no response.
//   APB port: capacity register at byte address 0 (5 bits, reset 16).
//   Write it only while the cache is idle.
// Timing
//   A request is accepted in idle. The search token walks the cell row one
//   cell per cycle, is captured in the hold register, and the update plus
//   the response register load happen in commit. The next request is
//   accepted only after the controller returns to idle, so one request is
//   in flight at a time; the length of the cell row sets the spacing.
// Reset
//   All entries invalid, occupancy zero, capacity 16.
// Stall
//   The response register holds while response_stall is high. A get whose
//   response register is still occupied waits in commit; request_stall
//   stays high until the request commits.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lkv_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lkv_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lkv_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // request channel
    input  lkv_pkg::req_t                       request,
    input  logic                                request_valid,
    output logic                                request_stall,
    // response channel
    output lkv_pkg::rsp_t                       response,
    output logic                                response_valid,
    input  logic                                response_stall
);
    import lkv_pkg::*;

    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_BITS) ? OCC_W : CAP_BITS;

    // controller
    state_t                 state_reg;
    state_t                 state_next;
    req_t                   req_reg;
    logic                   launch_reg;
    scan_t                  hold_reg;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic [CAP_BITS-1:0]    cap_reg;
    logic                   out_valid_reg;
    rsp_t                   out_data_reg;

    scan_t                  head_token;
    scan_t                  chain [ENTRIES+1];
    upd_t                   upd;

    logic                   accept;
    logic                   commit;
    logic                   is_get;
    logic                   out_free;
    logic                   out_load;
    logic                   cfg_write;
    reg_idx_t               reg_idx;
    logic [CMP_W-1:0]       cap_ext;
    logic [CMP_W-1:0]       eff_cap;
    logic [CMP_W-1:0]       occ_ext;
    logic                   evict;
    slot_t                  new_slot;

    // ------------------------------------------------------------------
    // APB: single capacity register, no wait states
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_CAPACITY: prdata = APB_DATA_W'(cap_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_write && (reg_idx == REG_CAPACITY))
            cap_reg <= pwdata[CAP_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Cell row: token enters at slot 0 in the cycle after accept
    // ------------------------------------------------------------------
    always_comb
    begin
        head_token        = '0;
        head_token.active = launch_reg;
    end

    assign chain[0] = head_token;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lkv_cell #(
            .ENTRIES (ENTRIES),
            .SLOT    (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan_in  (chain[g]),
            .scan_out (chain[g+1]),
            .key      (req_reg.key),
            .upd      (upd)
        );
    end

    // ------------------------------------------------------------------
    // Eviction decision. Capacity 0 acts as 1, above ENTRIES as ENTRIES.
    // ------------------------------------------------------------------
    assign cap_ext = CMP_W'(cap_reg);
    assign occ_ext = CMP_W'(occ_reg);

    always_comb
    begin
        if (cap_ext == '0)
            eff_cap = CMP_W'(1);
        else if (cap_ext > CMP_W'(ENTRIES))
            eff_cap = CMP_W'(ENTRIES);
        else
            eff_cap = cap_ext;
    end

    assign evict = (occ_ext >= eff_cap);

    // new pair goes to the lowest free slot, counting the victim as free
    always_comb
    begin
        if (evict && (!hold_reg.free_found || (hold_reg.old_slot < hold_reg.free_slot)))
            new_slot = hold_reg.old_slot;
        else
            new_slot = hold_reg.free_slot;
    end

    // ------------------------------------------------------------------
    // FSM
    // ------------------------------------------------------------------
    assign request_stall = (state_reg != ST_IDLE);
    assign accept        = request_valid && !request_stall;
    assign is_get        = (req_reg.operation == OP_GET);
    assign out_free      = !out_valid_reg || !response_stall;

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chain[ENTRIES].active)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // a get waits for room in the response register
                if (!is_get || out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_load = commit && is_get;

    // update command to all cells
    always_comb
    begin
        upd             = '0;
        upd.touch       = commit && hold_reg.hit;
        upd.write_data  = (req_reg.operation == OP_SET);
        upd.hit_slot    = hold_reg.hit_slot;
        upd.hit_rank    = hold_reg.hit_rank;
        upd.insert      = commit && !hold_reg.hit && (req_reg.operation == OP_SET);
        upd.evict       = evict;
        upd.victim_slot = hold_reg.old_slot;
        upd.new_slot    = new_slot;
        upd.key         = req_reg.key;
        upd.data        = req_reg.value;
    end

    always_comb
    begin
        occ_next = occ_reg;
        if (upd.insert && !evict)
            occ_next = OCC_W'(occ_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= accept;
            occ_reg    <= occ_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!response_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        if ((state_reg == ST_SCAN) && chain[ENTRIES].active)
            hold_reg <= chain[ENTRIES];
        if (out_load)
        begin
            out_data_reg.found      <= hold_reg.hit;
            out_data_reg.read_value <= hold_reg.hit ? hold_reg.hit_data : '1;
        end
    end

    assign response       = out_data_reg;
    assign response_valid = out_valid_reg;

endmodule

// ===== verif/lru_key_value_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb: self-checking bench for the LRU key-value cache
// Drives get/set requests and APB capacity writes, mirrors the store and its
// LRU order in a scoreboard, and compares every get response in order.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;

    import lkv_pkg::*;

    localparam int SLOTS      = 16;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 155;
    localparam int POOL_SIZE  = 32;
    // Slowest legal run is well under 1 ms; allow several times that.
    localparam int TIME_LIMIT = 5_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the store plus the queue of get responses owed.
    // ------------------------------------------------------------------------
    class lru_mirror;
        logic                  slot_valid [SLOTS];
        logic [KEY_BITS-1:0]   slot_key   [SLOTS];
        logic [VALUE_BITS-1:0] slot_data  [SLOTS];
        int unsigned           slot_rank  [SLOTS];
        int unsigned           fill;
        logic [CAP_BITS-1:0]   capacity;
        rsp_t                  owed_lookups [$];
        int                    mismatches;
        int                    gets, hits, sets, evictions;

        function new();
            foreach (slot_valid[i])
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i]  = 0;
            end
            fill       = 0;
            capacity   = CAP_RESET;
            mismatches = 0;
            gets       = 0;
            hits       = 0;
            sets       = 0;
            evictions  = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s", $realtime, msg);
        endfunction

        // zero acts as one, anything above the table size saturates
        function int unsigned cap_limit();
            if (capacity == 0)
                return 1;
            if (capacity > SLOTS)
                return SLOTS;
            return 32'(capacity);
        endfunction

        // every valid entry more recent than rank r gets one step older
        function void age_below(int unsigned r);
            foreach (slot_valid[i])
                if (slot_valid[i] && slot_rank[i] < r)
                    slot_rank[i]++;
        endfunction

        function void note_request(req_t r);
            int          hit_slot;
            int          victim;
            int          free_slot;
            int unsigned oldest;
            rsp_t        owed;
            hit_slot  = -1;
            victim    = -1;
            free_slot = -1;
            oldest    = 0;
            foreach (slot_valid[i])
                if (hit_slot < 0 && slot_valid[i] && slot_key[i] == r.key)
                    hit_slot = i;

            if (r.operation == OP_GET)
            begin
                gets++;
                if (hit_slot >= 0)
                begin
                    hits++;
                    age_below(slot_rank[hit_slot]);
                    slot_rank[hit_slot] = 0;
                    owed.found          = 1'b1;
                    owed.read_value     = slot_data[hit_slot];
                end
                else
                begin
                    owed.found      = 1'b0;
                    owed.read_value = '1;
                end
                owed_lookups.push_back(owed);
                return;
            end

            sets++;
            // rewrite of a present key: refresh, never evicts
            if (hit_slot >= 0)
            begin
                age_below(slot_rank[hit_slot]);
                slot_rank[hit_slot] = 0;
                slot_data[hit_slot] = r.value;
                return;
            end

            // at most one eviction per insert, even if capacity dropped lower
            if (fill >= cap_limit())
            begin
                foreach (slot_valid[i])
                    if (slot_valid[i] && (victim < 0 || slot_rank[i] >= oldest))
                    begin
                        victim = i;
                        oldest = slot_rank[i];
                    end
                if (victim >= 0)
                begin
                    slot_valid[victim] = 1'b0;
                    fill--;
                    evictions++;
                end
            end

            foreach (slot_valid[i])
                if (free_slot < 0 && !slot_valid[i])
                    free_slot = i;
            if (free_slot < 0)
                return;
            age_below(SLOTS + 1);
            slot_valid[free_slot] = 1'b1;
            slot_key[free_slot]   = r.key;
            slot_data[free_slot]  = r.value;
            slot_rank[free_slot]  = 0;
            fill++;
        endfunction

        function void check_response(rsp_t got);
            rsp_t owed;
            if (owed_lookups.size() == 0)
            begin
                flag($sformatf("response with none owed: found=%0b value=%08h",
                               got.found, got.read_value));
                return;
            end
            owed = owed_lookups.pop_front();
            if (got.found !== owed.found)
                flag($sformatf("found expected %0b, got %0b", owed.found, got.found));
            if (got.read_value !== owed.read_value)
                flag($sformatf("read_value expected %08h, got %08h",
                               owed.read_value, got.read_value));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    req_t                   request;
    logic                   request_valid;
    logic                   request_stall;
    rsp_t                   response;
    logic                   response_valid;
    logic                   response_stall;

    lru_key_value_cache #(
        .ENTRIES        (SLOTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .request        (request),
        .request_valid  (request_valid),
        .request_stall  (request_stall),
        .response       (response),
        .response_valid (response_valid),
        .response_stall (response_stall)
    );

    lru_mirror mirror = new();

    // Key pool: reusing a handful of keys is what makes hits and LRU
    // evictions common; the four corner keys are never replaced.
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  pool_used;

    bit gaps_on;     // sender inserts idle bursts
    bit stall_on;    // receiver inserts stall bursts
    bit calm_tail;   // final phase: full rate on both sides
    int cap_settings;

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIME_LIMIT);
        $display("Timeout: cache stopped making progress");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Response side: random stall bursts, with long calm stretches in
    // between; none at all during the last phase.
    // ------------------------------------------------------------------------
    initial
    begin
        int burst_left;
        burst_left     = 0;
        stall_on       = 1'b1;
        response_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 149) == 0)
                stall_on = !stall_on;
            if (calm_tail || !stall_on)
            begin
                burst_left = 0;
                response_stall <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                response_stall <= 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                response_stall <= 1'b1;
            end
            else
                response_stall <= 1'b0;
        end
    end

    // every accepted response is checked against the oldest owed lookup
    always @(posedge clk)
        if (rst_n && response_valid && !response_stall)
            mirror.check_response(response);

    // ------------------------------------------------------------------------
    // APB access. Each task begins on its own falling edge and ends with the
    // bus idle, so back-to-back accesses never touch a signal twice per step.
    // ------------------------------------------------------------------------
    task automatic apb_write(reg_idx_t idx, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // only the capacity register exists; other addresses are dropped
        if (idx == REG_CAPACITY)
            mirror.capacity = data[CAP_BITS-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_capacity();
        logic [APB_DATA_W-1:0] seen;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_CAPACITY, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        seen = prdata;
        if (seen[CAP_BITS-1:0] !== mirror.capacity)
            mirror.flag($sformatf("capacity readback expected %0d, got %0d",
                                  mirror.capacity, seen[CAP_BITS-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Request side. Called on a falling edge; returns on the falling edge
    // after the request was taken.
    // ------------------------------------------------------------------------
    task automatic send_request(req_t r);
        if (gaps_on && !calm_tail && $urandom_range(0, 3) == 0)
        begin
            request_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
        request       <= r;
        request_valid <= 1'b1;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        mirror.note_request(r);
        @(negedge clk);
    endtask

    function automatic req_t make_req(op_t op, logic [KEY_BITS-1:0] k,
                                      logic [VALUE_BITS-1:0] v);
        req_t r;
        r.operation = op;
        r.key       = k;
        r.value     = v;
        return r;
    endfunction

    // mostly pooled keys; now and then a fresh random key (almost always a miss)
    function automatic req_t random_request();
        logic [KEY_BITS-1:0] k;
        if ($urandom_range(0, 9) < 8)
            k = key_pool[$urandom_range(0, pool_used - 1)];
        else
            k = $urandom;
        return make_req($urandom_range(0, 1) ? OP_SET : OP_GET, k, $urandom);
    endfunction

    // Idle point for a register write: every owed get has come back, and a
    // trailing set gets a full pass through the cell row to commit.
    task automatic settle();
        request_valid <= 1'b0;
        while (mirror.owed_lookups.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8)
            @(posedge clk);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                    cap;
        logic [CAP_BITS-1:0]   cap_word;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        request       = '0;
        request_valid = 1'b0;
        gaps_on       = 1'b1;
        calm_tail     = 1'b0;
        cap_settings  = 1;
        rst_n         = 1'b0;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;
        pool_used = POOL_SIZE;

        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed: corner keys and values at the reset capacity ----
        check_capacity();
        send_request(make_req(OP_GET, 32'h0000_0000, 32'h0000_0000)); // empty miss
        send_request(make_req(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_req(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_req(OP_SET, 32'h0000_0000, 32'h0000_0000));
        send_request(make_req(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(OP_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_req(OP_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678));
        send_request(make_req(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF));
        send_request(make_req(OP_GET, 32'h1234_5678, 32'h0000_0000)); // miss
        // rewrite of a present key refreshes it without evicting
        send_request(make_req(OP_SET, 32'h0000_0000, 32'h5A5A_5A5A));
        send_request(make_req(OP_GET, 32'h0000_0000, 32'h0000_0000));

        // write to the unused address must leave capacity alone
        settle();
        apb_write(REG_NONE, 32'h0000_0003);
        check_capacity();

        // capacity dropped below occupancy: one eviction per new key only
        apb_write(REG_CAPACITY, 32'd2);
        check_capacity();
        cap_settings++;
        send_request(make_req(OP_SET, 32'h0000_0001, 32'h0000_0001));
        send_request(make_req(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h8000_0000, 32'h0000_0000));
        send_request(make_req(OP_GET, 32'h0000_0001, 32'h0000_0000));

        // smallest capacity: each new key replaces the last one
        settle();
        apb_write(REG_CAPACITY, 32'd1);
        check_capacity();
        cap_settings++;
        send_request(make_req(OP_SET, 32'hA5A5_A5A5, 32'h0F0F_0F0F));
        send_request(make_req(OP_SET, 32'h5A5A_5A5A, 32'hF0F0_F0F0));
        send_request(make_req(OP_GET, 32'hA5A5_A5A5, 32'h0000_0000));
        send_request(make_req(OP_SET, 32'h5A5A_5A5A, 32'h3C3C_C3C3));
        send_request(make_req(OP_GET, 32'h5A5A_5A5A, 32'h0000_0000));

        // ---- random phases, one capacity setting each ----
        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle();
            if (phase == 0 || phase == PHASES - 1)
                cap = SLOTS;
            else if (phase == 1)
                cap = 1;
            else
                cap = $urandom_range(1, SLOTS);
            cap_word = CAP_BITS'(cap);
            apb_write(REG_CAPACITY, {{(APB_DATA_W - CAP_BITS){1'b0}}, cap_word});
            check_capacity();
            cap_settings++;

            // pool a bit larger than the capacity keeps hits and misses mixed
            for (int i = 4; i < POOL_SIZE; i++)
                if ($urandom_range(0, 3) == 0)
                    key_pool[i] = $urandom;
            pool_used = cap + $urandom_range(1, cap + 1);
            if (pool_used > POOL_SIZE)
                pool_used = POOL_SIZE;

            calm_tail = (phase == PHASES - 1);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    gaps_on = !gaps_on;
                send_request(random_request());
            end
        end

        // ---- drain: everything owed returns, then a quiet window for strays
        settle();

        $display("Covered %0d gets (%0d hits) and %0d sets with %0d evictions",
                 mirror.gets, mirror.hits, mirror.sets, mirror.evictions);
        $display("over %0d capacity settings; %0d mismatches, %0d responses missing",
                 cap_settings, mirror.mismatches, mirror.owed_lookups.size());
        if (mirror.mismatches == 0 && mirror.owed_lookups.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
